FILE: sv/ttflp_pkg.sv
package ttflp_pkg;

    localparam int LEVELS     = 5;
    localparam int RATES      = 10;
    localparam int TIME_SLOTS = 1024;
    localparam int LOOKAHEAD  = 10;
    localparam int TASKS      = 6;
    localparam int CORES      = 3;

    localparam int ROWS      = LEVELS * RATES;
    localparam int TBL_DEPTH = ROWS * TIME_SLOTS;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int SLOT_W    = $clog2(TIME_SLOTS);
    localparam int SLOT_MAX  = TIME_SLOTS - 1 - LOOKAHEAD;

    localparam int LVL_W  = 3;
    localparam int RATE_W = 4;
    localparam int TASK_W = 3;
    localparam int CORE_W = 2;
    localparam int TEMP_W = 8;
    localparam int MAP_W  = 24;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 24;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TEMP_TARGET     = 3'd0,
        CFG_TEMP_MARGIN     = 3'd1,
        CFG_TASK_RATE_MAP   = 3'd2,
        CFG_DECISION_PERIOD = 3'd3
    } cfg_index_t;

    localparam logic [TEMP_W-1:0] RST_TEMP_TARGET     = 8'd70;
    localparam logic [TEMP_W-1:0] RST_TEMP_MARGIN     = 8'd5;
    localparam logic [MAP_W-1:0]  RST_TASK_RATE_MAP   = 24'h666333;
    localparam logic [7:0]        RST_DECISION_PERIOD = 8'd10;

    // flat store address: (level * RATES + rate) * TIME_SLOTS + slot
    function automatic logic [ADDR_W-1:0] tbl_addr(
        input logic [LVL_W-1:0]  lvl,
        input logic [RATE_W-1:0] rate,
        input logic [SLOT_W-1:0] slot
    );
        return ADDR_W'((32'(lvl) * RATES + 32'(rate)) * TIME_SLOTS + 32'(slot));
    endfunction

endpackage

FILE: sv/thermal_table_freq_level_picker.sv
// Table writes and ticks that do not close a decision period finish when accepted.
// A decision round runs one task at a time on the single table read port: a backward
// slot search of up to TIME_SLOTS reads (one per cycle), then up to LEVELS reads for the
// level pick, then one result hand-off, which waits for res_ready.
// Input is not taken during a round. Reset restores register defaults and clears task
// levels and tick count; the prediction store is not cleared and must be loaded first.
module thermal_table_freq_level_picker
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttflp_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [ttflp_pkg::CDAT_W-1:0]  cfg_data,

    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_type,
    input  logic [2:0]                    tbl_level,
    input  logic [3:0]                    tbl_rate,
    input  logic [9:0]                    tbl_time,
    input  logic [7:0]                    tbl_temp,
    input  logic [7:0]                    core_temp_1,
    input  logic [7:0]                    core_temp_2,
    input  logic [7:0]                    core_temp_3,

    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [2:0]                    task_number,
    output logic [2:0]                    freq_level,
    output logic [1:0]                    peak_core,
    output logic [7:0]                    peak_temp,
    output logic                          last
);
    import ttflp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LEVEL,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;

    logic [TEMP_W-1:0]     temp_target_reg, temp_target_next;
    logic [TEMP_W-1:0]     temp_margin_reg, temp_margin_next;
    logic [MAP_W-1:0]      rate_map_reg, rate_map_next;
    logic [7:0]            period_reg, period_next;

    logic [7:0]            tick_reg, tick_next;
    logic [LVL_W-1:0]      task_lvl_reg [TASKS];
    logic [LVL_W-1:0]      task_lvl_next [TASKS];

    logic [TASK_W-1:0]     task_reg, task_next;
    logic [SLOT_W-1:0]     t_reg, t_next;
    logic [SLOT_W-1:0]     rd_t_reg, rd_t_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [LVL_W-1:0]      lvl_cnt_reg, lvl_cnt_next;
    logic [LVL_W-1:0]      rd_lvl_reg, rd_lvl_next;
    logic                  rd_vld_reg, rd_vld_next;

    logic                  res_valid_reg, res_valid_next;
    logic [TASK_W-1:0]     task_number_reg, task_number_next;
    logic [LVL_W-1:0]      freq_level_reg, freq_level_next;
    logic [CORE_W-1:0]     peak_core_reg, peak_core_next;
    logic [TEMP_W-1:0]     peak_temp_reg, peak_temp_next;
    logic                  last_reg, last_next;

    logic [TEMP_W-1:0]     tbl_mem [TBL_DEPTH];
    logic [TEMP_W-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;

    logic                  req_acc;
    logic [TEMP_W-1:0]     core_temps [CORES];
    logic [RATE_W-1:0]     rate_raw, task_rate;
    logic [LVL_W-1:0]      cur_lvl;
    logic signed [9:0]     threshold;
    logic                  lvl_hit;
    logic [7:0]            tick_inc, period_eff;
    logic [SLOT_W-1:0]     found_t;
    logic                  go_level;

    assign cfg_ready   = 1'b1;
    assign req_ready   = (state_reg == ST_IDLE);
    assign req_acc     = req_valid && req_ready;
    assign res_valid   = res_valid_reg;
    assign task_number = task_number_reg;
    assign freq_level  = freq_level_reg;
    assign peak_core   = peak_core_reg;
    assign peak_temp   = peak_temp_reg;
    assign last        = last_reg;

    assign core_temps[0] = core_temp_1;
    assign core_temps[1] = core_temp_2;
    assign core_temps[2] = core_temp_3;

    assign wr_en = req_acc && !req_type && (32'(tbl_level) < LEVELS)
                   && (32'(tbl_rate) < RATES) && (32'(tbl_time) < TIME_SLOTS);

    assign rate_raw  = rate_map_reg[RATE_W*task_reg +: RATE_W];
    assign task_rate = (32'(rate_raw) > RATES - 1) ? RATE_W'(RATES - 1) : rate_raw;
    assign cur_lvl   = (32'(task_lvl_reg[task_reg]) > LEVELS - 1)
                       ? LVL_W'(LEVELS - 1) : task_lvl_reg[task_reg];

    assign threshold = $signed({2'b00, temp_target_reg}) - $signed({2'b00, temp_margin_reg});
    assign lvl_hit   = $signed({2'b00, rd_data_reg}) < threshold;

    assign tick_inc   = tick_reg + 8'd1;
    assign period_eff = (period_reg == 8'd0) ? 8'd1 : period_reg;

    always_comb
    begin
        if (state_reg == ST_LEVEL)
            rd_addr = tbl_addr(lvl_cnt_reg, task_rate, slot_reg);
        else
            rd_addr = tbl_addr(cur_lvl, task_rate, t_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tbl_mem[tbl_addr(tbl_level, tbl_rate, tbl_time[SLOT_W-1:0])] <= tbl_temp;
        rd_data_reg <= tbl_mem[rd_addr];
    end

    always_comb
    begin
        state_next       = state_reg;
        temp_target_next = temp_target_reg;
        temp_margin_next = temp_margin_reg;
        rate_map_next    = rate_map_reg;
        period_next      = period_reg;
        tick_next        = tick_reg;
        task_lvl_next    = task_lvl_reg;
        task_next        = task_reg;
        t_next           = t_reg;
        rd_t_next        = rd_t_reg;
        slot_next        = slot_reg;
        lvl_cnt_next     = lvl_cnt_reg;
        rd_lvl_next      = rd_lvl_reg;
        rd_vld_next      = rd_vld_reg;
        res_valid_next   = res_valid_reg;
        task_number_next = task_number_reg;
        freq_level_next  = freq_level_reg;
        peak_core_next   = peak_core_reg;
        peak_temp_next   = peak_temp_reg;
        last_next        = last_reg;
        found_t          = '0;
        go_level         = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEMP_TARGET:     temp_target_next = cfg_data[TEMP_W-1:0];
                CFG_TEMP_MARGIN:     temp_margin_next = cfg_data[TEMP_W-1:0];
                CFG_TASK_RATE_MAP:   rate_map_next    = cfg_data[MAP_W-1:0];
                CFG_DECISION_PERIOD: period_next      = cfg_data[7:0];
                default:             ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && req_type)
                begin
                    if (tick_inc < period_eff)
                        tick_next = tick_inc;
                    else
                    begin
                        tick_next      = '0;
                        peak_core_next = 2'd1;
                        peak_temp_next = '0;
                        // strict compare keeps the lower core on a tie
                        for (int c = 0; c < CORES; c++)
                        begin
                            if (core_temps[c] > peak_temp_next)
                            begin
                                peak_temp_next = core_temps[c];
                                peak_core_next = CORE_W'(c + 1);
                            end
                        end
                        task_next   = '0;
                        t_next      = SLOT_W'(TIME_SLOTS - 1);
                        rd_vld_next = 1'b0;
                        state_next  = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                // one read issued per cycle, the previous slot compared meanwhile
                if (rd_vld_reg && (peak_temp_reg >= rd_data_reg))
                begin
                    found_t  = rd_t_reg;
                    go_level = 1'b1;
                end
                else if (rd_vld_reg && (rd_t_reg == '0))
                begin
                    found_t  = '0;
                    go_level = 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b1;
                    rd_t_next   = t_reg;
                    t_next      = t_reg - SLOT_W'(1);
                end

                if (go_level)
                begin
                    slot_next = ((32'(found_t) > SLOT_MAX) ? SLOT_W'(SLOT_MAX) : found_t)
                                + SLOT_W'(LOOKAHEAD);
                    lvl_cnt_next = '0;
                    rd_vld_next  = 1'b0;
                    state_next   = ST_LEVEL;
                end
            end

            ST_LEVEL:
            begin
                if (rd_vld_reg && (lvl_hit || (32'(rd_lvl_reg) == LEVELS - 1)))
                begin
                    task_lvl_next[task_reg] = rd_lvl_reg;
                    freq_level_next  = rd_lvl_reg;
                    task_number_next = task_reg + TASK_W'(1);
                    last_next        = (32'(task_reg) == TASKS - 1);
                    res_valid_next   = 1'b1;
                    state_next       = ST_OUT;
                end
                else
                begin
                    rd_vld_next  = 1'b1;
                    rd_lvl_next  = lvl_cnt_reg;
                    lvl_cnt_next = lvl_cnt_reg + LVL_W'(1);
                end
            end

            ST_OUT:
            begin
                if (res_ready)
                begin
                    res_valid_next = 1'b0;
                    if (last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        task_next   = task_reg + TASK_W'(1);
                        t_next      = SLOT_W'(TIME_SLOTS - 1);
                        rd_vld_next = 1'b0;
                        state_next  = ST_SEARCH;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            temp_target_reg <= RST_TEMP_TARGET;
            temp_margin_reg <= RST_TEMP_MARGIN;
            rate_map_reg    <= RST_TASK_RATE_MAP;
            period_reg      <= RST_DECISION_PERIOD;
            tick_reg        <= '0;
            for (int i = 0; i < TASKS; i++)
                task_lvl_reg[i] <= '0;
            rd_vld_reg      <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            temp_target_reg <= temp_target_next;
            temp_margin_reg <= temp_margin_next;
            rate_map_reg    <= rate_map_next;
            period_reg      <= period_next;
            tick_reg        <= tick_next;
            task_lvl_reg    <= task_lvl_next;
            rd_vld_reg      <= rd_vld_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg        <= task_next;
        t_reg           <= t_next;
        rd_t_reg        <= rd_t_next;
        slot_reg        <= slot_next;
        lvl_cnt_reg     <= lvl_cnt_next;
        rd_lvl_reg      <= rd_lvl_next;
        task_number_reg <= task_number_next;
        freq_level_reg  <= freq_level_next;
        peak_core_reg   <= peak_core_next;
        peak_temp_reg   <= peak_temp_next;
        last_reg        <= last_next;
    end

    a_no_input_during_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req_ready)
        else $error("input taken while a result is pending");

    a_last_is_final_task: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && last) |-> (32'(task_number) == TASKS))
        else $error("last flag on wrong task");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (32'(freq_level) < LEVELS))
        else $error("chosen level out of range");

    a_idle_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && last) |=> (req_ready && !res_valid))
        else $error("round did not return to idle");

endmodule

FILE: dv/tb_thermal_table_freq_level_picker.sv
`timescale 1ns / 1ps

module tb_thermal_table_freq_level_picker;

    import ttflp_pkg::*;

    localparam logic              REQ_TABLE_WRITE  = 1'b0;
    localparam logic              REQ_TICK         = 1'b1;
    localparam logic [CIDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_LAST_UNUSED  = 3'd7;
    localparam int                SETTLE_CYCLES    = 16;
    localparam longint            CYCLE_LIMIT      = 4_000_000;
    localparam int                PHASES           = 7;
    localparam int                ITEMS_PER_PHASE  = 6;
    localparam int                MAX_REPORTS      = 40;
    localparam logic [3:0]        DEEP_RATE        = 4'(RATES - 1);
    localparam logic [3:0]        SHALLOW_RATE_A   = 4'd3;
    localparam logic [3:0]        SHALLOW_RATE_B   = 4'd6;
    localparam int                DEEP_BOTTOM      = 1012;
    localparam int                SHALLOW_BOTTOM   = 1022;

    typedef enum int {GAPS_NONE, GAPS_FULL, GAPS_RARE} gap_mode_t;

    typedef struct {
        logic       kind;
        logic [2:0] lvl;
        logic [3:0] rate;
        logic [9:0] slot;
        logic [7:0] temp;
        logic [7:0] core1;
        logic [7:0] core2;
        logic [7:0] core3;
    } req_item_t;

    typedef struct {
        logic [2:0] task_id;
        logic [2:0] level;
        logic [1:0] core;
        logic [7:0] temp;
        logic       end_flag;
    } pick_t;

    // Tracks the prediction store, per-task levels and tick count, and queues the
    // level picks each decision round should produce.
    class level_pick_tracker;
        logic [7:0]       forecast [LEVELS][RATES][TIME_SLOTS];
        logic [2:0]       cur_level [TASKS];
        logic [7:0]       ticks;
        logic [7:0]       target;
        logic [7:0]       margin;
        logic [7:0]       period;
        logic [MAP_W-1:0] rate_map;
        pick_t            pending_picks [$];
        int               errors;
        int               rounds;
        int               writes;
        int               tick_items;
        int               picks_seen;

        function new();
            foreach (cur_level[i]) cur_level[i] = '0;
            ticks      = '0;
            target     = RST_TEMP_TARGET;
            margin     = RST_TEMP_MARGIN;
            rate_map   = RST_TASK_RATE_MAP;
            period     = RST_DECISION_PERIOD;
            errors     = 0;
            rounds     = 0;
            writes     = 0;
            tick_items = 0;
            picks_seen = 0;
        endfunction

        function void apply_config(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
            case (idx)
                CFG_TEMP_TARGET:     target   = data[7:0];
                CFG_TEMP_MARGIN:     margin   = data[7:0];
                CFG_TASK_RATE_MAP:   rate_map = data[MAP_W-1:0];
                CFG_DECISION_PERIOD: period   = data[7:0];
                default: ;
            endcase
        endfunction

        function void note_request(req_item_t r);
            int unsigned per;
            int          limit;
            int          slot;
            int          lvl;
            int          t;
            int          c;
            int          k;
            logic [7:0]  hot;
            logic [1:0]  hot_idx;
            logic [7:0]  cores [CORES];
            logic [3:0]  rate;
            logic [2:0]  cur;
            pick_t       p;

            if (r.kind == REQ_TABLE_WRITE) begin
                writes++;
                if (r.lvl < LEVELS && r.rate < RATES && r.slot < TIME_SLOTS)
                    forecast[r.lvl][r.rate][r.slot] = r.temp;
                return;
            end
            tick_items++;
            per   = (period == 0) ? 1 : period;
            ticks = ticks + 8'd1;
            if (ticks < per)
                return;
            ticks = '0;
            rounds++;

            cores[0] = r.core1;
            cores[1] = r.core2;
            cores[2] = r.core3;
            hot      = '0;
            hot_idx  = 2'd1;
            // strict compare keeps the lower core on ties
            for (c = 0; c < CORES; c++) begin
                if (cores[c] > hot) begin
                    hot     = cores[c];
                    hot_idx = 2'(c + 1);
                end
            end
            limit = int'(target) - int'(margin);

            for (k = 0; k < TASKS; k++) begin
                rate = rate_map[4*k +: 4];
                if (rate > RATES - 1)
                    rate = 4'(RATES - 1);
                cur = cur_level[k];
                if (cur > LEVELS - 1)
                    cur = 3'(LEVELS - 1);
                slot = 0;
                for (t = TIME_SLOTS - 1; t >= 0; t--) begin
                    if (hot >= forecast[cur][rate][t]) begin
                        slot = t;
                        break;
                    end
                end
                if (slot > SLOT_MAX)
                    slot = SLOT_MAX;
                slot += LOOKAHEAD;
                for (lvl = 0; lvl < LEVELS; lvl++) begin
                    if (int'(forecast[lvl][rate][slot]) < limit)
                        break;
                end
                if (lvl >= LEVELS)
                    lvl = LEVELS - 1;
                cur_level[k] = 3'(lvl);

                p.task_id  = 3'(k + 1);
                p.level    = 3'(lvl);
                p.core     = hot_idx;
                p.temp     = hot;
                p.end_flag = (k == TASKS - 1);
                pending_picks.push_back(p);
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pick(pick_t got);
            pick_t want;
            picks_seen++;
            if (pending_picks.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual task %0d level %0d",
                             $time, got.task_id, got.level);
                errors++;
                return;
            end
            want = pending_picks.pop_front();
            compare_field("task_number", 8'(want.task_id), 8'(got.task_id));
            compare_field("freq_level", 8'(want.level), 8'(got.level));
            compare_field("peak_core", 8'(want.core), 8'(got.core));
            compare_field("peak_temp", want.temp, got.temp);
            compare_field("last", 8'(want.end_flag), 8'(got.end_flag));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CDAT_W-1:0] cfg_data;
    logic              req_valid;
    logic              req_ready;
    logic              req_type;
    logic [2:0]        tbl_level;
    logic [3:0]        tbl_rate;
    logic [9:0]        tbl_time;
    logic [7:0]        tbl_temp;
    logic [7:0]        core_temp_1;
    logic [7:0]        core_temp_2;
    logic [7:0]        core_temp_3;
    logic              res_valid;
    logic              res_ready;
    logic [2:0]        task_number;
    logic [2:0]        freq_level;
    logic [1:0]        peak_core;
    logic [7:0]        peak_temp;
    logic              last;

    level_pick_tracker tracker;
    gap_mode_t         send_gaps;
    gap_mode_t         sink_gaps;
    longint            cycles;
    int                cfg_writes;

    thermal_table_freq_level_picker uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned draw_gap(gap_mode_t mode);
        case (mode)
            GAPS_NONE: return 0;
            GAPS_FULL: return $urandom_range(0, 7);
            default:   return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 7) : 0;
        endcase
    endfunction

    // zero entry at the bottom of a loaded window ends every slot search there at the latest
    function automatic bit is_backstop(logic [3:0] rate, logic [9:0] slot);
        if (rate == DEEP_RATE)
            return slot == 10'(DEEP_BOTTOM);
        return (rate == SHALLOW_RATE_A || rate == SHALLOW_RATE_B)
               && slot == 10'(SHALLOW_BOTTOM);
    endfunction

    // temperature rises with level
    function automatic logic [7:0] load_temp(int lvl, int slot, int bottom);
        int v;
        if (slot == bottom)
            return 8'd0;
        v = 20 + lvl * 45 + $urandom_range(0, 20);
        return 8'(v);
    endfunction

    // only rates with a loaded window; nibbles above RATES-1 saturate to the deep rate
    function automatic logic [MAP_W-1:0] rand_map();
        logic [MAP_W-1:0] m;
        logic [3:0]       nib;
        int               k;
        m = '0;
        for (k = 0; k < TASKS; k++)
        begin
            case ($urandom_range(0, 2))
                0:       nib = SHALLOW_RATE_A;
                1:       nib = SHALLOW_RATE_B;
                default: nib = 4'($urandom_range(RATES - 1, 15));
            endcase
            m[4*k +: 4] = nib;
        end
        return m;
    endfunction

    function automatic req_item_t mk_write(logic [2:0] lvl, logic [3:0] rate,
                                           logic [9:0] slot, logic [7:0] temp);
        req_item_t r;
        r.kind  = REQ_TABLE_WRITE;
        r.lvl   = lvl;
        r.rate  = rate;
        r.slot  = slot;
        r.temp  = temp;
        r.core1 = 8'($urandom);
        r.core2 = 8'($urandom);
        r.core3 = 8'($urandom);
        return r;
    endfunction

    function automatic req_item_t mk_tick(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3);
        req_item_t r;
        r       = mk_write(3'($urandom), 4'($urandom), 10'($urandom), 8'($urandom));
        r.kind  = REQ_TICK;
        r.core1 = c1;
        r.core2 = c2;
        r.core3 = c3;
        return r;
    endfunction

    function automatic req_item_t random_item();
        req_item_t  r;
        logic [7:0] v;
        r.kind = ($urandom_range(0, 99) < 35) ? REQ_TABLE_WRITE : REQ_TICK;
        r.lvl  = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(LEVELS, 7))
                                             : 3'($urandom_range(0, LEVELS - 1));
        r.rate = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(RATES, 15))
                                             : 4'($urandom_range(0, RATES - 1));
        r.slot = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                             : 10'($urandom_range(DEEP_BOTTOM, TIME_SLOTS - 1));
        r.temp = 8'($urandom);
        if (r.kind == REQ_TABLE_WRITE && is_backstop(r.rate, r.slot))
            r.temp = '0;
        v      = 8'($urandom);
        r.core1 = 8'($urandom);
        r.core2 = 8'($urandom);
        r.core3 = 8'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                r.core1 = v;
                r.core2 = v;
                r.core3 = v;
            end
            1: begin
                r.core2 = v;
                r.core3 = v;
            end
            2: begin
                // cold cores push the slot search deep
                r.core1 = 8'($urandom_range(0, 31));
                r.core2 = 8'($urandom_range(0, 31));
                r.core3 = 8'($urandom_range(0, 31));
            end
            3: begin
                r.core1 = '0;
                r.core2 = '0;
                r.core3 = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(req_item_t r);
        int unsigned gap;
        gap = draw_gap(send_gaps);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= r.kind;
        tbl_level   <= r.lvl;
        tbl_rate    <= r.rate;
        tbl_time    <= r.slot;
        tbl_temp    <= r.temp;
        core_temp_1 <= r.core1;
        core_temp_2 <= r.core2;
        core_temp_3 <= r.core3;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        tracker.note_request(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (tracker.pending_picks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.apply_config(idx, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits of the 8-bit registers are junk and must be dropped
    task automatic set_phase(logic [7:0] tgt, logic [7:0] mar, logic [MAP_W-1:0] map,
                             logic [7:0] per);
        write_reg(CFG_TEMP_TARGET, {16'($urandom), tgt});
        write_reg(CFG_TEMP_MARGIN, {16'($urandom), mar});
        write_reg(CFG_TASK_RATE_MAP, map);
        write_reg(CFG_DECISION_PERIOD, {16'($urandom), per});
        write_reg(3'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)), 24'($urandom));
    endtask

    initial
    begin
        int        l;
        int        s;
        int        ph;
        int        n;

        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        req_valid   <= 1'b0;
        req_type    <= REQ_TABLE_WRITE;
        tbl_level   <= '0;
        tbl_rate    <= '0;
        tbl_time    <= '0;
        tbl_temp    <= '0;
        core_temp_1 <= '0;
        core_temp_2 <= '0;
        core_temp_3 <= '0;
        cfg_writes  = 0;
        tracker     = new();
        send_gaps   = GAPS_RARE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // only the top slots of the rates in use are loaded; the deep rate gets a
        // window low enough that the lookahead slot is not always clamped
        for (l = 0; l < LEVELS; l++)
        begin
            for (s = DEEP_BOTTOM; s < TIME_SLOTS; s++)
                send_item(mk_write(3'(l), DEEP_RATE, 10'(s), load_temp(l, s, DEEP_BOTTOM)));
            for (s = SHALLOW_BOTTOM; s < TIME_SLOTS; s++)
            begin
                send_item(mk_write(3'(l), SHALLOW_RATE_A, 10'(s),
                                   load_temp(l, s, SHALLOW_BOTTOM)));
                send_item(mk_write(3'(l), SHALLOW_RATE_B, 10'(s),
                                   load_temp(l, s, SHALLOW_BOTTOM)));
            end
        end

        // directed: reset settings, extreme writes, writes outside the store
        send_gaps = GAPS_FULL;
        send_item(mk_write(3'd0, 4'd0, 10'd0, 8'd255));
        send_item(mk_write(3'(LEVELS - 1), 4'(RATES - 1), 10'd1023, 8'd0));
        send_item(mk_write(3'd7, 4'd15, 10'd1023, 8'd255));
        send_item(mk_write(3'(LEVELS), 4'd3, 10'd512, 8'd0));
        send_item(mk_write(3'd2, 4'(RATES), 10'd7, 8'd99));
        for (n = 0; n < 9; n++)
            send_item(mk_tick(8'($urandom), 8'($urandom), 8'($urandom)));
        // tenth tick closes the period; all cores cold, search runs to the zero entry
        send_item(mk_tick(8'd0, 8'd0, 8'd0));
        wait_drained();
        write_reg(CFG_DECISION_PERIOD, 24'd1);
        send_item(mk_tick(8'd200, 8'd200, 8'd200));
        send_item(mk_tick(8'd10, 8'd255, 8'd255));
        send_item(mk_tick(8'd1, 8'd2, 8'd3));
        send_item(mk_tick(8'd255, 8'd0, 8'd0));
        wait_drained();
        // margin above target: threshold negative, every task saturates
        write_reg(CFG_TEMP_TARGET, 24'd3);
        write_reg(CFG_TEMP_MARGIN, 24'd200);
        send_item(mk_tick(8'd128, 8'd64, 8'd32));
        wait_drained();
        write_reg(CFG_LAST_UNUSED, 24'hFFFFFF);
        send_item(mk_tick(8'd90, 8'd90, 8'd40));

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: set_phase(8'($urandom), 8'($urandom_range(0, 40)), rand_map(), 8'd1);
                1: set_phase(8'd0, 8'd0, 24'hFFFFFF, 8'd2);
                2: set_phase(8'd255, 8'd0, 24'h333333, 8'd3);
                3: set_phase(8'd255, 8'd255, 24'h9F6A3C, 8'd255);
                4: set_phase(8'd80, 8'd10, 24'h369B63, 8'd0);
                5: set_phase(8'($urandom), 8'($urandom), rand_map(),
                             8'($urandom_range(1, 4)));
                default: set_phase(8'($urandom_range(40, 120)), 8'($urandom_range(0, 20)),
                                   rand_map(), 8'd1);
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_gaps = (send_gaps == GAPS_NONE) ? GAPS_FULL : GAPS_NONE;
                if (n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_item(random_item());
            end
        end
        wait_drained();

        $display("Covered %0d table writes and %0d ticks over %0d register writes",
                 tracker.writes, tracker.tick_items, cfg_writes);
        $display("%0d decision rounds, %0d task picks checked, %0d errors",
                 tracker.rounds, tracker.picks_seen, tracker.errors);
        if (tracker.errors == 0 && tracker.pending_picks.size() == 0)
            $display("thermal_table_freq_level_picker test passed");
        else
            $display("thermal_table_freq_level_picker test failed");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        pick_t       got;

        res_ready <= 1'b0;
        sink_gaps = GAPS_FULL;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        res_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (res_valid === 1'b1)
            begin
                got.task_id  = task_number;
                got.level    = freq_level;
                got.core     = peak_core;
                got.temp     = peak_temp;
                got.end_flag = last;
                tracker.check_pick(got);
                if ($urandom_range(0, 15) == 0)
                    sink_gaps = (sink_gaps == GAPS_NONE) ? GAPS_FULL : GAPS_NONE;
                stall = draw_gap(sink_gaps);
                if (stall > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    res_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("thermal_table_freq_level_picker test failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/ttflp_pkg.sv
sv/thermal_table_freq_level_picker.sv
dv/tb_thermal_table_freq_level_picker.sv
